>>> rtl/c65seq_pkg.sv
// Shared types and constants of the 6502 subset bus sequencer.
// Depends on nothing; c65seq_step and the top level refer to it by scoped names.
package c65seq_pkg;

    // Bus sequence position of the core
    typedef enum logic [3:0] {
        PH_RESET_LO  = 4'd0,
        PH_RESET_HI  = 4'd1,
        PH_FETCH     = 4'd2,
        PH_IMM       = 4'd3,
        PH_ABS_LO    = 4'd4,
        PH_ABS_HI    = 4'd5,
        PH_LOAD_A    = 4'd6,
        PH_RMW       = 4'd7,
        PH_WRITE_END = 4'd8,
        PH_JSR_LO    = 4'd9,
        PH_PULL_A    = 4'd10,
        PH_PULL_P    = 4'd11,
        PH_RTS_LO    = 4'd12,
        PH_RTS_HI    = 4'd13
    } t_phase;

    // Architectural state plus the pending bus access
    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  idx_x;
        logic [7:0]  idx_y;
        logic [7:0]  sp;
        logic [7:0]  status;
        logic [15:0] pc;
        logic [7:0]  opcode;
        t_phase      phase;
        logic [15:0] alat;
        logic        halt;
        logic [15:0] bus_addr;
        logic        bus_write;
        logic [7:0]  bus_data;
    } t_state;

    // Reset values
    localparam logic [15:0] VEC_RESET_LO = 16'hFFFC;
    localparam logic [15:0] VEC_RESET_HI = 16'hFFFD;
    localparam logic [7:0]  SP_RESET     = 8'hFD;
    localparam logic [7:0]  P_RESET      = 8'h24;
    localparam logic [7:0]  STACK_PAGE   = 8'h01;

    // Status bit positions
    localparam int unsigned FLAG_N_BIT = 7;
    localparam int unsigned FLAG_B_BIT = 4;
    localparam int unsigned FLAG_D_BIT = 3;
    localparam int unsigned FLAG_I_BIT = 2;
    localparam int unsigned FLAG_Z_BIT = 1;

    // Bits forced on in a pushed status byte
    localparam logic [7:0] P_PUSH_SET = 8'h30;

endpackage

>>> rtl/c65seq_if.sv
// Handshake channels of the sequencer: input request and result.
// Depends on nothing; valid/ready with the payload fields.
interface c65seq_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

interface c65seq_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_address;
    logic        next_is_write;
    logic [7:0]  next_write_data;
    logic        instruction_done;
    logic        halted;
    logic [7:0]  acc_value;
    logic [7:0]  index_x_value;
    logic [7:0]  index_y_value;
    logic [7:0]  stack_value;
    logic [7:0]  status_value;
    logic [15:0] counter_value;

    modport source (
        output valid, input ready,
        output next_address, output next_is_write, output next_write_data,
        output instruction_done, output halted,
        output acc_value, output index_x_value, output index_y_value,
        output stack_value, output status_value, output counter_value
    );
    modport sink (
        input valid, output ready,
        input next_address, input next_is_write, input next_write_data,
        input instruction_done, input halted,
        input acc_value, input index_x_value, input index_y_value,
        input stack_value, input status_value, input counter_value
    );
endinterface

>>> rtl/c65seq_step.sv
// Next-state logic of the sequencer: one completed bus access in, next access out.
// Depends on c65seq_pkg (state type, phases, constants).
module c65seq_step (
    input  c65seq_pkg::t_state i_state,
    input  logic [7:0]         i_read_data,
    output c65seq_pkg::t_state o_state,
    output logic               o_done
);

    // Implemented opcodes
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_BPL     = 8'h10;
    localparam logic [7:0] OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_STA_ABS = 8'h8D;
    localparam logic [7:0] OP_STA_ABX = 8'h9D;
    localparam logic [7:0] OP_STA_ABY = 8'h99;
    localparam logic [7:0] OP_INC_ABS = 8'hEE;
    localparam logic [7:0] OP_INC_ABX = 8'hFE;
    localparam logic [7:0] OP_DEC_ABS = 8'hCE;
    localparam logic [7:0] OP_DEC_ABX = 8'hDE;
    localparam logic [7:0] OP_JSR     = 8'h20;
    localparam logic [7:0] OP_SEI     = 8'h78;
    localparam logic [7:0] OP_CLD     = 8'hD8;
    localparam logic [7:0] OP_TXA     = 8'h8A;
    localparam logic [7:0] OP_TXS     = 8'h9A;
    localparam logic [7:0] OP_TAX     = 8'hAA;
    localparam logic [7:0] OP_TSX     = 8'hBA;
    localparam logic [7:0] OP_PHA     = 8'h48;
    localparam logic [7:0] OP_PHP     = 8'h08;
    localparam logic [7:0] OP_PLA     = 8'h68;
    localparam logic [7:0] OP_PLP     = 8'h28;
    localparam logic [7:0] OP_RTS     = 8'h60;

    // N and Z from a result byte
    function automatic logic [7:0] f_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p;
        r[c65seq_pkg::FLAG_N_BIT] = v[7];
        r[c65seq_pkg::FLAG_Z_BIT] = (v == 8'h00);
        return r;
    endfunction

    function automatic c65seq_pkg::t_state f_rd(input c65seq_pkg::t_state st,
                                                 input logic [15:0] a,
                                                 input c65seq_pkg::t_phase ph);
        c65seq_pkg::t_state r;
        r = st;
        r.bus_addr  = a;
        r.bus_write = 1'b0;
        r.bus_data  = 8'h00;
        r.phase     = ph;
        return r;
    endfunction

    function automatic c65seq_pkg::t_state f_wr(input c65seq_pkg::t_state st,
                                                 input logic [15:0] a,
                                                 input logic [7:0] dat,
                                                 input c65seq_pkg::t_phase ph);
        c65seq_pkg::t_state r;
        r = st;
        r.bus_addr  = a;
        r.bus_write = 1'b1;
        r.bus_data  = dat;
        r.phase     = ph;
        return r;
    endfunction

    // Push writes at the current SP, then post-decrements
    function automatic c65seq_pkg::t_state f_push(input c65seq_pkg::t_state st,
                                                   input logic [7:0] dat,
                                                   input c65seq_pkg::t_phase ph);
        c65seq_pkg::t_state r;
        r = f_wr(st, {c65seq_pkg::STACK_PAGE, st.sp}, dat, ph);
        r.sp = st.sp - 8'd1;
        return r;
    endfunction

    // Pull pre-increments, then reads
    function automatic c65seq_pkg::t_state f_pull(input c65seq_pkg::t_state st,
                                                   input c65seq_pkg::t_phase ph);
        c65seq_pkg::t_state r;
        logic [7:0] sp1;
        sp1 = st.sp + 8'd1;
        r = f_rd(st, {c65seq_pkg::STACK_PAGE, sp1}, ph);
        r.sp = sp1;
        return r;
    endfunction

    always_comb begin
        c65seq_pkg::t_state s;
        logic [7:0]  d;
        logic [7:0]  v;
        logic [15:0] ret;
        logic        done;

        s    = i_state;
        d    = i_read_data;
        v    = 8'h00;
        ret  = 16'h0000;
        done = 1'b0;

        // A halted core holds everything and repeats its last read
        if (!s.halt) begin
            unique case (s.phase)
                c65seq_pkg::PH_RESET_LO: begin
                    s.alat = {8'h00, d};
                    s = f_rd(s, c65seq_pkg::VEC_RESET_HI, c65seq_pkg::PH_RESET_HI);
                end
                c65seq_pkg::PH_RESET_HI: begin
                    s.pc = {d, s.alat[7:0]};
                    done = 1'b1;
                    s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                end
                c65seq_pkg::PH_FETCH: begin
                    s.opcode = d;
                    s.pc = s.pc + 16'd1;
                    done = 1'b1;
                    unique case (d) inside
                        OP_LDA_IMM, OP_LDX_IMM, OP_LDY_IMM, OP_BPL: begin
                            done = 1'b0;
                            s = f_rd(s, s.pc, c65seq_pkg::PH_IMM);
                        end
                        OP_LDA_ABS, OP_STA_ABS, OP_STA_ABX, OP_STA_ABY, OP_INC_ABS,
                        OP_INC_ABX, OP_DEC_ABS, OP_DEC_ABX, OP_JSR: begin
                            done = 1'b0;
                            s = f_rd(s, s.pc, c65seq_pkg::PH_ABS_LO);
                        end
                        OP_SEI: begin
                            s.status[c65seq_pkg::FLAG_I_BIT] = 1'b1;
                            s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                        end
                        OP_CLD: begin
                            s.status[c65seq_pkg::FLAG_D_BIT] = 1'b0;
                            s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                        end
                        OP_TXA: begin
                            s.acc = s.idx_x;
                            s.status = f_nz(s.status, s.idx_x);
                            s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                        end
                        OP_TXS: begin
                            s.sp = s.idx_x;
                            s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                        end
                        OP_TAX: begin
                            s.idx_x = s.acc;
                            s.status = f_nz(s.status, s.acc);
                            s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                        end
                        OP_TSX: begin
                            s.idx_x = s.sp;
                            s.status = f_nz(s.status, s.sp);
                            s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                        end
                        OP_PHA: begin
                            done = 1'b0;
                            s = f_push(s, s.acc, c65seq_pkg::PH_WRITE_END);
                        end
                        OP_PHP: begin
                            done = 1'b0;
                            s = f_push(s, s.status | c65seq_pkg::P_PUSH_SET,
                                       c65seq_pkg::PH_WRITE_END);
                        end
                        OP_PLA: begin
                            done = 1'b0;
                            s = f_pull(s, c65seq_pkg::PH_PULL_A);
                        end
                        OP_PLP: begin
                            done = 1'b0;
                            s = f_pull(s, c65seq_pkg::PH_PULL_P);
                        end
                        OP_RTS: begin
                            done = 1'b0;
                            s = f_pull(s, c65seq_pkg::PH_RTS_LO);
                        end
                        default: begin
                            // unknown opcode: stop for good
                            done = 1'b0;
                            s.halt = 1'b1;
                            s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                        end
                    endcase
                end
                c65seq_pkg::PH_IMM: begin
                    s.pc = s.pc + 16'd1;
                    if (s.opcode == OP_LDA_IMM) begin
                        s.acc = d;
                        s.status = f_nz(s.status, d);
                    end else if (s.opcode == OP_LDX_IMM) begin
                        s.idx_x = d;
                        s.status = f_nz(s.status, d);
                    end else if (s.opcode == OP_LDY_IMM) begin
                        s.idx_y = d;
                        s.status = f_nz(s.status, d);
                    end else if (!s.status[c65seq_pkg::FLAG_N_BIT]) begin
                        // branch taken: signed offset
                        s.pc = s.pc + {{8{d[7]}}, d};
                    end
                    done = 1'b1;
                    s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                end
                c65seq_pkg::PH_ABS_LO: begin
                    s.pc = s.pc + 16'd1;
                    s.alat = {8'h00, d};
                    s = f_rd(s, s.pc, c65seq_pkg::PH_ABS_HI);
                end
                c65seq_pkg::PH_ABS_HI: begin
                    s.pc = s.pc + 16'd1;
                    s.alat = {d, s.alat[7:0]};
                    unique case (s.opcode) inside
                        OP_LDA_ABS: s = f_rd(s, s.alat, c65seq_pkg::PH_LOAD_A);
                        OP_STA_ABS: s = f_wr(s, s.alat, s.acc, c65seq_pkg::PH_WRITE_END);
                        OP_STA_ABX: s = f_wr(s, s.alat + {8'h00, s.idx_x}, s.acc,
                                             c65seq_pkg::PH_WRITE_END);
                        OP_STA_ABY: s = f_wr(s, s.alat + {8'h00, s.idx_y}, s.acc,
                                             c65seq_pkg::PH_WRITE_END);
                        OP_INC_ABS, OP_DEC_ABS: s = f_rd(s, s.alat, c65seq_pkg::PH_RMW);
                        OP_INC_ABX, OP_DEC_ABX: begin
                            s.alat = s.alat + {8'h00, s.idx_x};
                            s = f_rd(s, s.alat, c65seq_pkg::PH_RMW);
                        end
                        default: begin
                            // JSR: push return address high byte
                            ret = s.pc - 16'd1;
                            s = f_push(s, ret[15:8], c65seq_pkg::PH_JSR_LO);
                        end
                    endcase
                end
                c65seq_pkg::PH_LOAD_A, c65seq_pkg::PH_PULL_A: begin
                    s.acc = d;
                    s.status = f_nz(s.status, d);
                    done = 1'b1;
                    s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                end
                c65seq_pkg::PH_RMW: begin
                    if (s.opcode == OP_INC_ABS || s.opcode == OP_INC_ABX) begin
                        v = d + 8'd1;
                    end else begin
                        v = d - 8'd1;
                    end
                    s.status = f_nz(s.status, v);
                    s = f_wr(s, s.alat, v, c65seq_pkg::PH_WRITE_END);
                end
                c65seq_pkg::PH_JSR_LO: begin
                    ret = s.pc - 16'd1;
                    s = f_push(s, ret[7:0], c65seq_pkg::PH_WRITE_END);
                    s.pc = s.alat;
                end
                c65seq_pkg::PH_PULL_P: begin
                    s.status = d;
                    s.status[c65seq_pkg::FLAG_B_BIT] = 1'b0;
                    done = 1'b1;
                    s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                end
                c65seq_pkg::PH_RTS_LO: begin
                    s.alat = {8'h00, d};
                    s = f_pull(s, c65seq_pkg::PH_RTS_HI);
                end
                c65seq_pkg::PH_RTS_HI: begin
                    s.pc = {d, s.alat[7:0]} + 16'd1;
                    done = 1'b1;
                    s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                end
                default: begin
                    // end of a write access
                    done = 1'b1;
                    s = f_rd(s, s.pc, c65seq_pkg::PH_FETCH);
                end
            endcase
        end

        o_state = s;
        o_done  = done;
    end

endmodule

>>> rtl/cpu_6502_subset_bus_sequencer.sv
// Top level of the 6502 subset bus sequencer: state registers and result register.
// Depends on c65seq_pkg, c65seq_if (channels) and c65seq_step (next-state logic).
//
// Each request carries the byte read by the bus access just completed; each
// result names the next access and shows the register file. The block takes
// one request per clock unless the result side stalls: the register state
// advances at the accepting edge and the matching result is presented in the
// cycle after from a single output register. A request is taken whenever that
// register is empty or is being drained in the same cycle, so with the result side
// always ready the rate is one access per clock, and the path that sets the clock
// is the one-access decode between the state registers and the result register.
module cpu_6502_subset_bus_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    c65seq_req_if.sink        i_req,
    c65seq_res_if.source      o_res
);

    c65seq_pkg::t_state r_state;
    c65seq_pkg::t_state n_state;
    logic               n_done;
    logic               r_out_valid;
    logic               r_out_done;
    logic               w_accept;

    // Handshake: one output register parts the two sides
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    c65seq_step u_step (
        .i_state     (r_state),
        .i_read_data (i_req.read_data),
        .o_state     (n_state),
        .o_done      (n_done)
    );

    // Architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.acc       <= 8'h00;
            r_state.idx_x     <= 8'h00;
            r_state.idx_y     <= 8'h00;
            r_state.sp        <= c65seq_pkg::SP_RESET;
            r_state.status    <= c65seq_pkg::P_RESET;
            r_state.pc        <= 16'h0000;
            r_state.opcode    <= 8'h00;
            r_state.phase     <= c65seq_pkg::PH_RESET_LO;
            r_state.alat      <= 16'h0000;
            r_state.halt      <= 1'b0;
            r_state.bus_addr  <= c65seq_pkg::VEC_RESET_LO;
            r_state.bus_write <= 1'b0;
            r_state.bus_data  <= 8'h00;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Done flag of the result; the rest of the payload is the state itself
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_done <= n_done;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.next_address     = r_state.bus_addr;
    assign o_res.next_is_write    = r_state.bus_write;
    assign o_res.next_write_data  = r_state.bus_write ? r_state.bus_data : 8'h00;
    assign o_res.instruction_done = r_out_done;
    assign o_res.halted           = r_state.halt;
    assign o_res.acc_value        = r_state.acc;
    assign o_res.index_x_value    = r_state.idx_x;
    assign o_res.index_y_value    = r_state.idx_y;
    assign o_res.stack_value      = r_state.sp;
    assign o_res.status_value     = r_state.status;
    assign o_res.counter_value    = r_state.pc;

    // Halt is sticky
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halt |=> r_state.halt)
        else $error("halt flag dropped");

    // A halted core never reports a finished instruction
    a_halt_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_state.halt && $past(r_state.halt)) |-> !r_out_done)
        else $error("instruction done while halted");

    // Every accepted request produces a result in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted request without result");

    // While a result waits, the state it shows does not move
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(r_state))
        else $error("state changed under a stalled result");

endmodule
